FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, gated by the synchronous reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, gated by the synchronous reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/utce_pkg.sv
`timescale 1ns / 1ps
package utce_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 32;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_MIN_YEAR = 1'b0;  // register index, taken from paddr[2]

  // Calendar constants
  localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [YEAR_W-1:0] LAST_YEAR      = 12'd2106;  // later years overflow 32 bits
  localparam logic [YEAR_W-1:0] SKIP_LEAP_YEAR = 12'd2100;  // only century non-leap in range
  localparam logic [YEAR_W-1:0] MIN_YEAR_RST   = 12'd1970;
  localparam logic [9:0]        LEAPS_BASE     = 10'd492;   // 1969 / 4

  // Days in month, index is month - 1 (February as non-leap)
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mi);
    logic [DAY_W-1:0] len;
    case (mi)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month, index is month - 1
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/utce_ifs.sv
`timescale 1ns / 1ps
// Date/time input channel
interface utce_in_if;
  import utce_pkg::*;
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

// Epoch result channel
interface utce_out_if;
  import utce_pkg::*;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, valid_res, epoch_seconds, input ready);
  modport sink   (input valid, valid_res, epoch_seconds, output ready);
endinterface

FILE: sv/utc_datetime_to_epoch_top.sv
`timescale 1ns / 1ps
// UTC date/time to Unix epoch seconds.
//
// in_ch carries one item per handshake: year, month, day, hour, minute,
// second. out_ch returns one item per input item, in order: valid_res and
// epoch_seconds (zero when the item is rejected). An item is rejected for a
// year below minimum_year or 1970 or above 2106, any calendar field out of range, or a
// count above 2^32-1.
// The datapath is a four-stage pipeline: field checks and day-of-year,
// day count and time of day, multiply by 86400, final add and range check.
// An accepted item's result moves through the stage 1 to 4 registers to out_ch;
// one item per cycle is sustained while out_ch is ready; every stage advances each cycle.
// Each stage holds its item while the next one is full and stalled, so a
// stall on out_ch backs up stage by stage; bubbles still fill up.
// Reset (rst_n low, synchronous) empties the pipeline and sets minimum_year
// to 1970. minimum_year sits at cfg address 0; the user must write it over APB
// only while the block is idle, which the block itself does not enforce; pready is always high.
module utc_datetime_to_epoch_top (
  input  logic                         clk,
  input  logic                         rst_n,
  utce_in_if.sink                      in_ch,
  utce_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [utce_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [utce_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [utce_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import utce_pkg::*;
  `include "assert_macros.svh"

  // ---------------- configuration ----------------
  logic [YEAR_W-1:0] min_year_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MIN_YEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
    end else if (cfg_wr) begin
      min_year_r <= cfg_pwdata[YEAR_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MIN_YEAR) begin
      cfg_prdata = {{(CFG_DW-YEAR_W){1'b0}}, min_year_r};
    end
  end

  // ---------------- stage valids and flow control ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !s4_v_r || out_ch.ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_ch.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------- stage 1: checks, year offset, leap count, day of year ----------------
  logic                year_ok, mon_ok, time_ok, day_ok, leap;
  logic [MONTH_W-1:0]  mi;
  logic [DAY_W-1:0]    mlen;
  logic [YEAR_W-1:0]   yr_off, yr_m1;
  logic [9:0]          leaps_full;
  logic [8:0]          doy_nxt;

  logic                s1_ok_r;
  logic [7:0]          s1_dy_r;
  logic [5:0]          s1_leaps_r;
  logic [8:0]          s1_doy_r;
  logic [HOUR_W-1:0]   s1_hour_r;
  logic [MINUTE_W-1:0] s1_min_r;
  logic [SECOND_W-1:0] s1_sec_r;

  always_comb begin
    year_ok = (in_ch.year >= min_year_r) && (in_ch.year >= EPOCH_YEAR) &&
              (in_ch.year <= LAST_YEAR);
    mon_ok  = (in_ch.month >= 4'd1) && (in_ch.month <= 4'd12);
    time_ok = (in_ch.hour <= 5'd23) && (in_ch.minute <= 6'd59) && (in_ch.second <= 6'd59);
    // within 1970..2106 only 2100 breaks the every-fourth-year rule
    leap    = (in_ch.year[1:0] == 2'b00) && (in_ch.year != SKIP_LEAP_YEAR);
    mi      = in_ch.month - 4'd1;
    mlen    = (mi == 4'd1 && leap) ? 5'd29 : month_len(mi);
    day_ok  = (in_ch.day >= 5'd1) && (in_ch.day <= mlen);
    yr_off  = in_ch.year - EPOCH_YEAR;
    yr_m1   = in_ch.year - 12'd1;
    // leap years in [1970, year-1]
    leaps_full = yr_m1[YEAR_W-1:2] - LEAPS_BASE - {9'd0, (in_ch.year > SKIP_LEAP_YEAR)};
    doy_nxt = cum_days(mi) + {8'd0, (mi >= 4'd2) && leap} + {4'd0, in_ch.day} - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_ok_r    <= year_ok && mon_ok && time_ok && day_ok;
      s1_dy_r    <= yr_off[7:0];
      s1_leaps_r <= leaps_full[5:0];
      s1_doy_r   <= doy_nxt;
      s1_hour_r  <= in_ch.hour;
      s1_min_r   <= in_ch.minute;
      s1_sec_r   <= in_ch.second;
    end
  end

  // ---------------- stage 2: day count and time of day ----------------
  logic        s2_ok_r;
  logic [15:0] s2_days_r;
  logic [16:0] s2_tod_r;

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_ok_r   <= s1_ok_r;
      s2_days_r <= {8'd0, s1_dy_r} * 16'd365 + {10'd0, s1_leaps_r} + {7'd0, s1_doy_r};
      s2_tod_r  <= {12'd0, s1_hour_r} * 17'd3600 + {11'd0, s1_min_r} * 17'd60 +
                   {11'd0, s1_sec_r};
    end
  end

  // ---------------- stage 3: days to seconds ----------------
  logic        s3_ok_r;
  logic [32:0] s3_prod_r;
  logic [16:0] s3_tod_r;

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_ok_r   <= s2_ok_r;
      s3_prod_r <= {17'd0, s2_days_r} * 33'd86400;
      s3_tod_r  <= s2_tod_r;
    end
  end

  // ---------------- stage 4: final add, 32-bit range check, output ----------------
  logic [33:0]        sum;
  logic               res_ok;
  logic               s4_res_r;
  logic [EPOCH_W-1:0] s4_epoch_r;

  assign sum    = {1'b0, s3_prod_r} + {17'd0, s3_tod_r};
  assign res_ok = s3_ok_r && (sum[33:32] == 2'b00);

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_res_r   <= res_ok;
      s4_epoch_r <= res_ok ? sum[EPOCH_W-1:0] : '0;
    end
  end

  assign out_ch.valid         = s4_v_r;
  assign out_ch.valid_res     = s4_res_r;
  assign out_ch.epoch_seconds = s4_epoch_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_reject_zero, clk, rst_n, s4_v_r && !s4_res_r, s4_epoch_r == '0)
  `ASSERT_IMPL(a_empty_out_ready, clk, rst_n, !s4_v_r, in_ch.ready)
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v_r && !rdy2, s1_v_r)
  `ASSERT_NEXT(a_s3_hold, clk, rst_n, s3_v_r && !rdy4, s3_v_r && $stable(s3_prod_r))

endmodule
